FILE: src/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escape-framed message deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

    // Default payload buffer depth
    localparam int BUFFER_DEPTH_DEF = 128;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W   = 32;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd92;
    localparam logic [BYTE_W-1:0] STOP_CODE_RST   = 8'd48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE_CODE = 1'b0,
        REG_STOP_CODE   = 1'b1
    } cfg_index_t;

    // Result kinds
    typedef enum logic {
        KIND_PAYLOAD  = 1'b0,
        KIND_COMPLETE = 1'b1
    } result_kind_t;

    // Live configuration
    typedef struct packed {
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] stop_code;
    } cfg_t;

    // One result item
    typedef struct packed {
        result_kind_t      result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] message_type;
        logic [POS_W-1:0]  message_length;
    } result_t;

endpackage

FILE: src/efd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_decoder
// Per-byte escape decode: holds the escape flag, pending message type and
// length counter, and forms at most one result for each processed byte.
// ----------------------------------------------------------------------------
module efd_decoder #(
    parameter int BUFFER_DEPTH = efd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [efd_pkg::BYTE_W-1:0] rx_byte,
    input  efd_pkg::cfg_t             cfg,
    output logic                      res_valid,
    output efd_pkg::result_t          res
);

    localparam int LEN_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_DEPTH - 1);

    logic                       esc_pending_reg, esc_pending_next;
    logic [efd_pkg::BYTE_W-1:0] pend_type_reg, pend_type_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       is_esc, is_stop;
    logic [LEN_W+efd_pkg::POS_W-1:0] len_ext;

    assign is_esc  = (rx_byte == cfg.escape_code);
    assign is_stop = (rx_byte == cfg.stop_code);
    // Low bits of the counter, zero-extended for shallow buffers
    assign len_ext = {{efd_pkg::POS_W{1'b0}}, len_reg};

    // Decode and next state
    always_comb begin
        esc_pending_next   = esc_pending_reg;
        pend_type_next     = pend_type_reg;
        len_next           = len_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.result_kind    = efd_pkg::KIND_PAYLOAD;
        if (!esc_pending_reg && is_esc) begin
            esc_pending_next = 1'b1;
        end else if (esc_pending_reg && !is_esc) begin
            esc_pending_next = 1'b0;
            if (is_stop) begin
                // Completion; no report without a type
                pend_type_next = '0;
                if (pend_type_reg != '0) begin
                    res_valid          = 1'b1;
                    res.result_kind    = efd_pkg::KIND_COMPLETE;
                    res.message_type   = pend_type_reg;
                    res.message_length = len_ext[efd_pkg::POS_W-1:0];
                end
            end else begin
                pend_type_next = rx_byte;
                len_next       = '0;
            end
        end else begin
            // Payload byte (plain, or literal escape)
            esc_pending_next  = 1'b0;
            len_next          = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
            res_valid         = 1'b1;
            res.payload_byte  = rx_byte;
            res.byte_position = len_ext[efd_pkg::POS_W-1:0];
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pending_reg <= 1'b0;
            pend_type_reg   <= '0;
            len_reg         <= '0;
        end else if (step) begin
            esc_pending_reg <= esc_pending_next;
            pend_type_reg   <= pend_type_next;
            len_reg         <= len_next;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("length counter above buffer depth");
    a_complete_typed: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.result_kind == efd_pkg::KIND_COMPLETE |->
        res.message_type != '0)
        else $error("completion reported with no type");
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.result_kind == efd_pkg::KIND_PAYLOAD |->
        res.message_type == '0 && res.message_length == '0)
        else $error("payload result carries message fields");
    a_escape_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !esc_pending_reg && is_esc |=> esc_pending_reg)
        else $error("escape byte did not arm flag");
`endif

endmodule

FILE: src/efd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_out_reg
// Result register on the master side; holds a result until its transfer.
// ----------------------------------------------------------------------------
module efd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  efd_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output efd_pkg::result_t m_res
);

    logic             vld_reg, vld_next;
    efd_pkg::result_t res_reg;

    // Register can take a new result when empty or draining
    assign free = !vld_reg || m_tready;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_res    = res_reg;

endmodule

FILE: src/escape_framed_message_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_framed_message_deframer_core
// Escape byte-stuffing deframer: one received byte in, at most one payload
// or message-complete result out.
//
// Channel   Dir  Handshake             Content
// s_        in   s_tvalid/s_tready     rx_byte
// m_        out  m_tvalid/m_tready     result fields, kind in m_tuser
// cfg_      in   cfg_valid/cfg_ready   register index and data
//
// One byte per cycle sustained while the result register is free; a byte
// passes the input register, then decode into the result register.
// Reset (aresetn low, synchronous) clears both registers' valid flags, the
// decode state and restores escape 92 and stop 48.
// A stalled result register holds the decode stage; one more byte still
// lands in the input register only if that register is empty.
// ----------------------------------------------------------------------------
module escape_framed_message_deframer_core #(
    parameter int BUFFER_DEPTH = efd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // rx_byte[7:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [efd_pkg::BYTE_W-1:0]     s_tdata,
    // payload_byte[7:0], byte_position[14:8], message_type[22:15],
    // message_length[29:23], zero[31:30]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [efd_pkg::TDATA_W-1:0]    m_tdata,
    // result_kind[0]
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efd_pkg::BYTE_W-1:0]     cfg_data
);

    logic                       in_vld_reg, in_vld_next;
    logic [efd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       advance;
    logic                       out_free;
    logic                       res_valid;
    efd_pkg::result_t           res, m_res;
    efd_pkg::cfg_t              cfg_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_code <= efd_pkg::ESCAPE_CODE_RST;
            cfg_reg.stop_code   <= efd_pkg::STOP_CODE_RST;
        end else if (cfg_valid) begin
            case (efd_pkg::cfg_index_t'(cfg_index))
                efd_pkg::REG_ESCAPE_CODE: cfg_reg.escape_code <= cfg_data;
                efd_pkg::REG_STOP_CODE:   cfg_reg.stop_code   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Decode
    efd_decoder #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    efd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // Pack master-side fields
    assign m_tuser = m_res.result_kind;
    assign m_tdata = {2'b00, m_res.message_length, m_res.message_type,
                      m_res.byte_position, m_res.payload_byte};

endmodule
